[rtl/core/dubt_pkg.sv]
// dubt_pkg: shared constants, types and codes of the universe buffer table
// no dependencies
`timescale 1ns / 1ps
package dubt_pkg;
  localparam int MAX_BUFFERS_DEF = 32;
  localparam int SLOTS_DEF = 512;

  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_END  = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;
  localparam logic [1:0] ACT_READ = 2'd3;

  localparam logic [2:0] REG_PIXEL_MODE = 3'd0;
  localparam logic [2:0] REG_START      = 3'd1;
  localparam logic [2:0] REG_COUNT      = 3'd2;
  localparam logic [2:0] REG_EFFECT     = 3'd3;
  localparam logic [2:0] REG_ALL        = 3'd4;
  localparam logic [2:0] REG_TIMEOUT    = 3'd5;

  typedef struct packed {
    logic        pixel_mode;
    logic [15:0] start_universe;
    logic [15:0] effect_universe;
    logic [15:0] all_universe;
    logic [15:0] timeout_ms;
    logic [1:0]  action;
    logic [15:0] universe;
    logic [31:0] now_ms;
  } cell_cmd_t;

  typedef struct packed {
    logic       found;
    logic [6:0] index;
  } cell_hit_t;
endpackage

[rtl/core/dubt_ram.sv]
// dubt_ram: generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module dubt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

[rtl/core/dubt_cell.sv]
// dubt_cell: one buffer entry with tag compare, valid flag and last-seen time
// depends on dubt_pkg
`timescale 1ns / 1ps
module dubt_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               active,
  input  logic               clear,
  input  logic               step,
  input  dubt_pkg::cell_cmd_t cmd,
  input  dubt_pkg::cell_hit_t hit_in,
  output dubt_pkg::cell_hit_t hit_out,
  input  logic               stamp,
  input  logic [6:0]         stamp_idx,
  output logic               valid
);
  logic        valid_r, valid_nxt;
  logic [31:0] seen_r, seen_nxt;
  logic [15:0] tag;
  logic [31:0] age;

  always_comb begin
    if (cmd.pixel_mode) tag = cmd.start_universe + 16'(IDX);
    else if (IDX == 0) tag = cmd.effect_universe;
    else tag = cmd.all_universe;
    hit_out = hit_in;
    if (!hit_in.found && active && tag == cmd.universe) begin
      hit_out.found = 1'b1;
      hit_out.index = 7'(IDX);
    end
    age = cmd.now_ms - seen_r;
    valid_nxt = valid_r;
    seen_nxt = seen_r;
    if (step && cmd.action == dubt_pkg::ACT_TICK && active && age > {16'd0, cmd.timeout_ms})
      valid_nxt = 1'b0;
    if (stamp && stamp_idx == 7'(IDX)) begin
      valid_nxt = 1'b1;
      seen_nxt = cmd.now_ms;
    end
    if (clear) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      seen_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      seen_r <= seen_nxt;
    end
  end
  assign valid = valid_r & active;
endmodule

[rtl/core/dmx_universe_buffer_table_core.sv]
// dmx_universe_buffer_table_core: universe buffer table top level
// depends on dubt_pkg, dubt_cell, dubt_ram
// flow: accepted item registered, S_LOOK (tag lookup, ram read), S_READ loads out_tdata
// packet end on a tracked universe goes through S_FILL, zero-filling slots past its length
// one item in flight; S_READ waits for the result register, whose load frees the core
// reset: synchronous active-low, control registers reset, flags cleared, ram untouched
`timescale 1ns / 1ps
module dmx_universe_buffer_table_core #(
  parameter int MAX_BUFFERS = dubt_pkg::MAX_BUFFERS_DEF,
  parameter int SLOTS_PER_UNIVERSE = dubt_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // action, universe, slot, slot_value, packet_length, now_ms
  input  logic [95:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // matched, buffer_index, read_value, universe_valid, pixel_data_valid,
  // effect_data_valid
  output logic [23:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int SW = (SLOTS_PER_UNIVERSE > 1) ? $clog2(SLOTS_PER_UNIVERSE) : 1;
  localparam int BW = $clog2(MAX_BUFFERS);
  localparam int DEPTH = MAX_BUFFERS * (1 << SW);
  localparam int AW = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_LOOK = 4'b0010, S_FILL = 4'b0100, S_READ = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic        pm_r;
  logic [15:0] start_r, eff_r, all_r, tmo_r;
  logic [5:0]  cnt_r;
  logic [1:0]  act_r;
  logic [15:0] uni_r, slot_r, plen_r;
  logic [7:0]  val_r;
  logic [31:0] now_r;
  logic        hit_r;
  logic [BW-1:0] idx_r;
  logic [16:0] fill_r, fill_nxt;
  logic [23:0] out_r;
  logic        outv_r;
  logic        out_load;
  logic        cfg_clear;
  dubt_pkg::cell_cmd_t cmd;
  dubt_pkg::cell_hit_t chain [MAX_BUFFERS+1];
  logic [MAX_BUFFERS-1:0] vflags;
  logic [6:0]  nact;
  logic        ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]  ram_wd, ram_rd;
  logic        slot_ok;
  logic        stamp;

  assign cfg_ready = 1'b1;
  assign cfg_clear = cfg_valid && cfg_index <= dubt_pkg::REG_TIMEOUT;
  assign in_tready = state_r == S_IDLE;
  assign out_load = state_r == S_READ && (!outv_r || out_tready);
  assign out_tvalid = outv_r;
  assign out_tdata = out_r;

  always_comb begin
    if (pm_r) nact = ({1'b0, cnt_r} > 7'(MAX_BUFFERS)) ? 7'(MAX_BUFFERS) : {1'b0, cnt_r};
    else nact = 7'd2;
  end

  assign cmd = '{pixel_mode: pm_r, start_universe: start_r, effect_universe: eff_r,
                 all_universe: all_r, timeout_ms: tmo_r, action: act_r,
                 universe: uni_r, now_ms: now_r};
  assign chain[0] = '{found: 1'b0, index: 7'd0};
  assign stamp = state_r == S_LOOK && act_r == dubt_pkg::ACT_END && chain[MAX_BUFFERS].found;

  for (genvar g = 0; g < MAX_BUFFERS; g++) begin : g_cell
    dubt_cell #(.IDX(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .active(7'(g) < nact), .clear(cfg_clear),
      .step(state_r == S_LOOK), .cmd(cmd), .hit_in(chain[g]), .hit_out(chain[g+1]),
      .stamp(stamp), .stamp_idx(chain[MAX_BUFFERS].index), .valid(vflags[g])
    );
  end

  assign slot_ok = slot_r < 16'(SLOTS_PER_UNIVERSE);

  always_comb begin
    ram_we = 1'b0;
    ram_wd = 8'd0;
    ram_addr = AW'({idx_r, slot_r[SW-1:0]});
    if (state_r == S_LOOK) begin
      ram_addr = AW'({chain[MAX_BUFFERS].index[BW-1:0], slot_r[SW-1:0]});
      if (act_r == dubt_pkg::ACT_BYTE && chain[MAX_BUFFERS].found && slot_ok) begin
        ram_we = 1'b1;
        ram_wd = val_r;
      end
    end else if (state_r == S_FILL) begin
      ram_addr = AW'({idx_r, fill_r[SW-1:0]});
      ram_we = fill_r < 17'(SLOTS_PER_UNIVERSE);
    end
  end

  dubt_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
  );

  always_comb begin
    state_nxt = state_r;
    fill_nxt = fill_r;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_LOOK;
      S_LOOK: begin
        if (act_r == dubt_pkg::ACT_END && chain[MAX_BUFFERS].found) begin
          state_nxt = S_FILL;
          fill_nxt = (plen_r > 16'(SLOTS_PER_UNIVERSE)) ? 17'(SLOTS_PER_UNIVERSE)
                                                        : {1'b0, plen_r};
        end else state_nxt = S_READ;
      end
      S_FILL: begin
        if (fill_r >= 17'(SLOTS_PER_UNIVERSE)) state_nxt = S_READ;
        else fill_nxt = fill_r + 17'd1;
      end
      S_READ: if (!outv_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pm_r <= 1'b0; start_r <= 16'd1; cnt_r <= 6'd1;
      eff_r <= 16'd1; all_r <= 16'd2; tmo_r <= 16'd2500;
      hit_r <= 1'b0;
      outv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          dubt_pkg::REG_PIXEL_MODE: pm_r <= cfg_data[0];
          dubt_pkg::REG_START:      start_r <= cfg_data;
          dubt_pkg::REG_COUNT:      cnt_r <= cfg_data[5:0];
          dubt_pkg::REG_EFFECT:     eff_r <= cfg_data;
          dubt_pkg::REG_ALL:        all_r <= cfg_data;
          dubt_pkg::REG_TIMEOUT:    tmo_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == S_LOOK) hit_r <= chain[MAX_BUFFERS].found && act_r != dubt_pkg::ACT_TICK;
      if (out_load) outv_r <= 1'b1;
      else if (out_tready) outv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    fill_r <= fill_nxt;
    if (in_tvalid && in_tready) begin
      act_r <= in_tdata[1:0];
      uni_r <= in_tdata[17:2];
      slot_r <= in_tdata[33:18];
      val_r <= in_tdata[41:34];
      plen_r <= in_tdata[57:42];
      now_r <= in_tdata[89:58];
    end
    if (state_r == S_LOOK) idx_r <= chain[MAX_BUFFERS].index[BW-1:0];
    if (out_load) begin
      out_r <= {7'd0, !pm_r && vflags[0], pm_r && (|vflags), hit_r && vflags[idx_r],
                (hit_r && act_r == dubt_pkg::ACT_READ && slot_ok) ? ram_rd : 8'd0,
                hit_r ? 5'(idx_r) : 5'd0, hit_r};
    end
  end
endmodule

[tb/tb_dmx_universe_buffer_table_core.sv]
// testbench for dmx_universe_buffer_table_core: directed and random items checked
// against a scoreboard that models the tag table, flags, ageing and slot store
// depends on dubt_pkg and the core rtl
`timescale 1ns / 1ps
module tb_dmx_universe_buffer_table_core;
  localparam int NBUF = 32;
  localparam int NSLOT = 512;
  localparam int LIMIT = 3000000;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] universe;
    logic [15:0] slot;
    logic [7:0]  slot_value;
    logic [15:0] packet_length;
    logic [31:0] now_ms;
  } dmx_item_t;

  class universe_table_sb;
    logic [7:0]  slots [NBUF][NSLOT];
    bit          written [NBUF][NSLOT];
    bit          flags [NBUF];
    logic [31:0] seen [NBUF];
    logic        pix;
    logic [15:0] start_u, effect_u, all_u, tmo;
    logic [5:0]  count;
    logic [23:0] pending [$];
    int          errors;

    function new();
      pix = 0; start_u = 1; count = 1; effect_u = 1; all_u = 2; tmo = 2500;
      errors = 0;
      foreach (flags[i]) begin
        flags[i] = 0;
        seen[i] = 0;
      end
    endfunction

    function int active();
      if (pix) return (count > NBUF) ? NBUF : count;
      return 2;
    endfunction

    function logic [15:0] tag_of(int i);
      if (pix) return start_u + 16'(i);
      return (i == 0) ? effect_u : all_u;
    endfunction

    function int find(logic [15:0] u);
      for (int i = 0; i < active(); i++)
        if (tag_of(i) == u) return i;
      return -1;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] d);
      case (idx)
        dubt_pkg::REG_PIXEL_MODE: pix = d[0];
        dubt_pkg::REG_START:      start_u = d;
        dubt_pkg::REG_COUNT:      count = d[5:0];
        dubt_pkg::REG_EFFECT:     effect_u = d;
        dubt_pkg::REG_ALL:        all_u = d;
        dubt_pkg::REG_TIMEOUT:    tmo = d;
        default:                  return;
      endcase
      foreach (flags[i]) flags[i] = 0;
    endfunction

    function void note_item(dmx_item_t it);
      int hit;
      int lo;
      logic [7:0] rd;
      bit any;
      logic [23:0] r;
      hit = -1;
      rd = 0;
      any = 0;
      if (it.action == dubt_pkg::ACT_TICK) begin
        for (int i = 0; i < active(); i++)
          if (flags[i] && (it.now_ms - seen[i]) > {16'd0, tmo}) flags[i] = 0;
      end else begin
        hit = find(it.universe);
        if (hit >= 0) begin
          if (it.action == dubt_pkg::ACT_BYTE) begin
            if (it.slot < NSLOT) begin
              slots[hit][it.slot] = it.slot_value;
              written[hit][it.slot] = 1;
            end
          end else if (it.action == dubt_pkg::ACT_END) begin
            lo = (it.packet_length > NSLOT) ? NSLOT : it.packet_length;
            for (int s = lo; s < NSLOT; s++) begin
              slots[hit][s] = 0;
              written[hit][s] = 1;
            end
            seen[hit] = it.now_ms;
            flags[hit] = 1;
          end else if (it.slot < NSLOT) begin
            rd = slots[hit][it.slot];
          end
        end
      end
      for (int i = 0; i < active(); i++)
        if (flags[i]) any = 1;
      r = '0;
      r[0]    = (hit >= 0);
      r[5:1]  = (hit >= 0) ? 5'(hit) : 5'd0;
      r[13:6] = rd;
      r[14]   = (hit >= 0) && flags[hit];
      r[15]   = pix && any;
      r[16]   = !pix && flags[0];
      pending.push_back(r);
    endfunction

    function void check(logic [23:0] got);
      logic [23:0] exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp %b/%0d/%h/%b/%b/%b got %b/%0d/%h/%b/%b/%b pad %h",
                   exp_r[0], exp_r[5:1], exp_r[13:6], exp_r[14], exp_r[15], exp_r[16],
                   got[0], got[5:1], got[13:6], got[14], got[15], got[16], got[23:17]);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [23:0] out_tdata;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  universe_table_sb sb;
  int          cycles = 0;
  bit          hold_req = 0;
  bit          quiet = 0;
  logic [31:0] now_ms;

  dmx_universe_buffer_table_core dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check(out_tdata);

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_req && hold == 0) begin
        hold = 400;
        hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 0;
      end else if (quiet) begin
        out_tready <= 1;
      end else if ($urandom_range(0, 99) < 3) begin
        hold = $urandom_range(10, 40);
        out_tready <= 0;
      end else begin
        out_tready <= ($urandom_range(0, 99) < 75);
      end
    end
  end

  function automatic int pick_gap();
    int p;
    if (quiet) return 0;
    p = $urandom_range(0, 99);
    if (p < 70) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(dmx_item_t it);
    int g;
    int h;
    if (it.action == dubt_pkg::ACT_READ) begin
      h = sb.find(it.universe);
      if (h >= 0 && it.slot < NSLOT && !sb.written[h][it.slot])
        it.slot = 16'(NSLOT + $urandom_range(0, 65535 - NSLOT));
    end
    in_tvalid <= 1;
    in_tdata <= {6'd0, it.now_ms, it.packet_length, it.slot_value, it.slot,
                 it.universe, it.action};
    do @(posedge clk); while (!in_tready);
    sb.note_item(it);
    g = pick_gap();
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_f(logic [1:0] a, logic [15:0] u, logic [15:0] s, logic [7:0] v,
                        logic [15:0] pl, logic [31:0] t);
    dmx_item_t it;
    it = '{a, u, s, v, pl, t};
    send(it);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [15:0] d);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_universe();
    int n;
    n = sb.active();
    if (n > 0 && $urandom_range(0, 99) < 85) return sb.tag_of($urandom_range(0, n - 1));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_slot();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 16'($urandom_range(0, 15));
    if (p < 92) return 16'($urandom_range(0, NSLOT - 1));
    return 16'($urandom_range(NSLOT, 65535));
  endfunction

  function automatic logic [15:0] pick_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return 16'($urandom_range(0, 16));
    if (p < 85) return 16'($urandom_range(0, NSLOT));
    if (p < 90) return 16'(NSLOT);
    return 16'($urandom_range(NSLOT + 1, 65535));
  endfunction

  task automatic random_items(int total);
    int sent;
    int p;
    int k;
    logic [15:0] u;
    logic [95:0] rnd;
    dmx_item_t it;
    sent = 0;
    while (sent < total) begin
      p = $urandom_range(0, 99);
      if (p < 55) begin
        u = pick_universe();
        k = $urandom_range(0, 10);
        repeat (k) begin
          send_f(dubt_pkg::ACT_BYTE, u, pick_slot(), 8'($urandom), 16'($urandom), now_ms);
          sent++;
        end
        now_ms += $urandom_range(0, 800);
        send_f(dubt_pkg::ACT_END, u, 16'($urandom), 8'($urandom), pick_len(), now_ms);
        sent++;
        repeat ($urandom_range(1, 4)) begin
          send_f(dubt_pkg::ACT_READ, u, pick_slot(), 8'($urandom), 16'($urandom), now_ms);
          sent++;
        end
      end else if (p < 72) begin
        if ($urandom_range(0, 3) == 0) now_ms += sb.tmo + $urandom_range(0, 2);
        else now_ms += $urandom_range(0, 3000);
        send_f(dubt_pkg::ACT_TICK, 16'($urandom), 16'($urandom), 8'($urandom),
               16'($urandom), now_ms);
        sent++;
      end else if (p < 88) begin
        send_f(dubt_pkg::ACT_READ, pick_universe(), pick_slot(), 8'($urandom),
               16'($urandom), now_ms);
        sent++;
      end else begin
        rnd = {$urandom, $urandom, $urandom};
        it = rnd[89:0];
        if (it.action == dubt_pkg::ACT_END && $urandom_range(0, 1))
          it.packet_length = 16'(NSLOT + 1);
        send(it);
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    now_ms = 32'hFFFF_F000;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset settings, effect mode with universes 1 and 2
    send_f(dubt_pkg::ACT_BYTE, 16'd1, 16'd0, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_f(dubt_pkg::ACT_BYTE, 16'd1, 16'd1, 8'hA5, 16'd0, 32'd0);
    send_f(dubt_pkg::ACT_BYTE, 16'd1, 16'd511, 8'h00, 16'd0, 32'd0);
    send_f(dubt_pkg::ACT_BYTE, 16'd1, 16'd512, 8'h5A, 16'd0, 32'd0);
    send_f(dubt_pkg::ACT_BYTE, 16'd1, 16'hFFFF, 8'h5A, 16'd0, 32'd0);
    send_f(dubt_pkg::ACT_BYTE, 16'hFFFF, 16'd3, 8'h11, 16'd0, 32'd0);
    send_f(dubt_pkg::ACT_END, 16'hFFFF, 16'd0, 8'd0, 16'd0, 32'd0);
    send_f(dubt_pkg::ACT_END, 16'd1, 16'd0, 8'd0, 16'd2, 32'hFFFF_FFFF);
    send_f(dubt_pkg::ACT_END, 16'd2, 16'd0, 8'd0, 16'hFFFF, 32'd0);
    send_f(dubt_pkg::ACT_READ, 16'd1, 16'd0, 8'd0, 16'd0, 32'd0);
    send_f(dubt_pkg::ACT_READ, 16'd1, 16'd1, 8'd0, 16'd0, 32'd0);
    send_f(dubt_pkg::ACT_READ, 16'd1, 16'd300, 8'd0, 16'd0, 32'd0);
    send_f(dubt_pkg::ACT_READ, 16'd1, 16'd511, 8'd0, 16'd0, 32'd0);
    send_f(dubt_pkg::ACT_READ, 16'd1, 16'd600, 8'd0, 16'd0, 32'd0);
    send_f(dubt_pkg::ACT_READ, 16'd2, 16'd5, 8'd0, 16'd0, 32'd0);
    send_f(dubt_pkg::ACT_READ, 16'd0, 16'd0, 8'd0, 16'd0, 32'd0);
    send_f(dubt_pkg::ACT_TICK, 16'd0, 16'd0, 8'd0, 16'd0, 32'd2499);
    send_f(dubt_pkg::ACT_TICK, 16'd0, 16'd0, 8'd0, 16'd0, 32'd2500);
    send_f(dubt_pkg::ACT_TICK, 16'd0, 16'd0, 8'd0, 16'd0, 32'd2501);
    send_f(dubt_pkg::ACT_END, 16'd1, 16'd0, 8'd0, 16'd0, 32'd5);
    send_f(dubt_pkg::ACT_END, 16'd2, 16'd0, 8'd0, 16'd512, 32'hFFFF_FFFF);
    send_f(dubt_pkg::ACT_TICK, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    quiet = 1;
    random_items(120);
    quiet = 0;
    drain();

    // pixel mode wrapping past 65535, full count, long hold-off on the receiver
    write_cfg(dubt_pkg::REG_PIXEL_MODE, 16'd1);
    write_cfg(dubt_pkg::REG_START, 16'hFFF0);
    write_cfg(dubt_pkg::REG_COUNT, 16'd32);
    write_cfg(dubt_pkg::REG_TIMEOUT, 16'd0);
    hold_req = 1;
    quiet = 1;
    random_items(100);
    quiet = 0;
    random_items(150);
    drain();

    // count above the table size, long timeout, out-of-list index
    write_cfg(dubt_pkg::REG_COUNT, 16'hFFFF);
    write_cfg(dubt_pkg::REG_START, 16'd0);
    write_cfg(dubt_pkg::REG_TIMEOUT, 16'hFFFF);
    random_items(200);
    drain();
    write_cfg(REG_UNUSED, 16'hFFFF);
    random_items(60);
    drain();

    // pixel mode with no buffers
    write_cfg(dubt_pkg::REG_COUNT, 16'd0);
    random_items(50);
    drain();

    // effect mode, both tags equal, then extremes
    write_cfg(dubt_pkg::REG_PIXEL_MODE, 16'd0);
    write_cfg(dubt_pkg::REG_EFFECT, 16'd7);
    write_cfg(dubt_pkg::REG_ALL, 16'd7);
    write_cfg(dubt_pkg::REG_TIMEOUT, 16'd100);
    random_items(120);
    drain();
    write_cfg(dubt_pkg::REG_EFFECT, 16'hFFFF);
    write_cfg(dubt_pkg::REG_ALL, 16'd0);
    now_ms = $urandom;
    random_items(200);
    drain();

    // small pixel range, middle settings
    write_cfg(dubt_pkg::REG_PIXEL_MODE, 16'd1);
    write_cfg(dubt_pkg::REG_START, 16'd1000);
    write_cfg(dubt_pkg::REG_COUNT, 16'd3);
    write_cfg(dubt_pkg::REG_TIMEOUT, 16'd1500);
    random_items(200);
    drain();

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
